>>> hw/rtl/keyed_table_with_compaction_top_assert.svh
// assertion macros for the keyed table with compaction
`ifndef KEYED_TABLE_WITH_COMPACTION_TOP_ASSERT_SVH
`define KEYED_TABLE_WITH_COMPACTION_TOP_ASSERT_SVH

// same-cycle implication, held off during reset
`define KTC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ktc assertion failed");

// next-cycle implication, held off during reset
`define KTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ktc assertion failed");

// next-cycle implication that also holds across reset
`define KTC_ASSERT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("ktc assertion failed");

`endif

>>> hw/rtl/ktc_pkg.sv
// shared types and constants for the keyed table with compaction
`default_nettype none

package ktc_pkg;

    localparam int DEPTH     = 64;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CAP_W     = 7;
    localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int KEY_W     = 32;
    localparam int PAY_W     = 64;
    localparam int ECNT_W    = 7;
    localparam int S_TDATA_W = 2 * KEY_W + PAY_W;
    localparam int M_RAW_W   = KEY_W + PAY_W + ECNT_W;
    localparam int M_TDATA_W = ((M_RAW_W + 7) / 8) * 8;
    localparam int CAP_RST   = (DEPTH < 64) ? DEPTH : 64;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [PAY_W-1:0]        payload_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic [CAP_W-1:0]        cap_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_DEL = 2'd1,
        OP_UPD = 2'd2,
        OP_GET = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_DUP  = 2'd2,
        ST_MISS = 2'd3
    } status_t;

    // commit strobes from the sequencer to every cell
    typedef struct packed {
        logic add_en;
        logic upd_en;
        logic del_en;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/ktc_cell.sv
// one table cell: stored entry, key compare and shift toward lower index
`default_nettype none

module ktc_cell (
    input  wire logic              aclk,
    input  wire ktc_pkg::idx_t     cell_idx,
    input  wire ktc_pkg::cnt_t     count,
    input  wire logic              cmp_en,
    input  wire ktc_pkg::key_t     cmp_key,
    input  wire ktc_pkg::key_t     cmp_new_key,
    input  wire ktc_pkg::cell_ctrl_t ctrl,
    input  wire ktc_pkg::key_t     wr_key,
    input  wire ktc_pkg::payload_t wr_payload,
    input  wire ktc_pkg::key_t     nbr_key,
    input  wire ktc_pkg::payload_t nbr_payload,
    input  wire logic              shift_in,
    output ktc_pkg::key_t          key,
    output ktc_pkg::payload_t      payload,
    output logic                   hit_key,
    output logic                   hit_new_key,
    output logic                   shift_out
);
    import ktc_pkg::*;

    key_t     key_reg;
    payload_t payload_reg;
    logic     hit_key_reg;
    logic     hit_new_key_reg;
    logic     occupied;
    logic     add_here;

    // entry is live when its index lies below the fill count
    assign occupied  = {{(CNT_W - IDX_W){1'b0}}, cell_idx} < count;
    assign add_here  = {{(CNT_W - IDX_W){1'b0}}, cell_idx} == count;
    assign shift_out = shift_in | hit_key_reg;

    // compare flags captured when the transaction is taken
    always_ff @(posedge aclk) begin
        if (cmp_en) begin
            hit_key_reg     <= occupied && (key_reg == cmp_key);
            hit_new_key_reg <= occupied && (key_reg == cmp_new_key);
        end
    end

    // entry storage: append, in-place update, or compaction shift
    always_ff @(posedge aclk) begin
        if (ctrl.add_en && add_here) begin
            key_reg     <= wr_key;
            payload_reg <= wr_payload;
        end else if (ctrl.upd_en && hit_key_reg) begin
            key_reg     <= wr_key;
            payload_reg <= wr_payload;
        end else if (ctrl.del_en && shift_out) begin
            key_reg     <= nbr_key;
            payload_reg <= nbr_payload;
        end
    end

    assign key         = key_reg;
    assign payload     = payload_reg;
    assign hit_key     = hit_key_reg;
    assign hit_new_key = hit_new_key_reg;

endmodule

`default_nettype wire

>>> hw/rtl/keyed_table_with_compaction_top.sv
// keyed table top level: row of entry cells, sequencer and result register
// a transaction is compared in every cell when taken, then committed across the cell row, and its result
// is registered at the commit, which waits while a held result is not taken; no new transaction is taken
//   before that commit, and the compaction shift ripples combinationally through the row
// reset: aresetn low clears fill count, sequencer and result valid, capacity returns to 64
// stored entries are not cleared; only entries below the fill count are ever read
`default_nettype none

module keyed_table_with_compaction_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [ktc_pkg::CAP_W-1:0]      cfg_wdata,    // capacity
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [ktc_pkg::S_TDATA_W-1:0]  s_tdata,      // key, new_key, payload
    input  wire logic [1:0]                     s_tuser,      // opcode
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [ktc_pkg::M_TDATA_W-1:0]       m_tdata,      // found_key, found_payload,
                                                              // entry_count, zero pad
    output logic [1:0]                          m_tuser       // status
);
    import ktc_pkg::*;

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'b01,
        SEQ_EXEC = 2'b10
    } seq_state_t;

    seq_state_t state_reg, state_next;
    cnt_t       count_reg, count_next;
    cap_t       cap_reg;
    opcode_t    op_reg;
    key_t       item_key_reg, item_new_key_reg;
    payload_t   item_payload_reg;

    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    status_t              m_status_reg;

    logic       accept, out_free, commit;
    key_t       s_key, s_new_key;
    payload_t   s_payload;
    cell_ctrl_t ctrl;
    key_t       wr_key;

    key_t     cell_key     [DEPTH];
    payload_t cell_payload [DEPTH];
    logic [DEPTH-1:0] hit_key_vec, hit_new_key_vec;
    logic [DEPTH:0]   shift_chain;

    logic     any_hit, any_new_hit, full;
    payload_t sel_payload;
    status_t  status;
    key_t     res_key;
    payload_t res_payload;
    logic [CMP_W-1:0] cfg_ext;

    // unpack input fields
    assign s_key     = s_tdata[KEY_W-1:0];
    assign s_new_key = s_tdata[2*KEY_W-1:KEY_W];
    assign s_payload = s_tdata[S_TDATA_W-1:2*KEY_W];

    assign s_tready = (state_reg == SEQ_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign commit   = (state_reg == SEQ_EXEC) && out_free;

    // capacity register, saturated to table depth
    assign cfg_ext = {{(CMP_W - CAP_W){1'b0}}, cfg_wdata};
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_W'(CAP_RST);
        end else if (cfg_we) begin
            cap_reg <= (cfg_ext > CMP_W'(DEPTH)) ? CAP_W'(DEPTH) : cfg_wdata;
        end
    end

    // item capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg           <= opcode_t'(s_tuser);
            item_key_reg     <= s_key;
            item_new_key_reg <= s_new_key;
            item_payload_reg <= s_payload;
        end
    end

    // row of cells; the compaction flag ripples from low to high index
    assign shift_chain[0] = 1'b0;
    assign wr_key = (op_reg == OP_UPD) ? item_new_key_reg : item_key_reg;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        localparam int NBR = (i == DEPTH - 1) ? i : i + 1;
        ktc_cell u_cell (
            .aclk        (aclk),
            .cell_idx    (IDX_W'(i)),
            .count       (count_reg),
            .cmp_en      (accept),
            .cmp_key     (s_key),
            .cmp_new_key (s_new_key),
            .ctrl        (ctrl),
            .wr_key      (wr_key),
            .wr_payload  (item_payload_reg),
            .nbr_key     (cell_key[NBR]),
            .nbr_payload (cell_payload[NBR]),
            .shift_in    (shift_chain[i]),
            .key         (cell_key[i]),
            .payload     (cell_payload[i]),
            .hit_key     (hit_key_vec[i]),
            .hit_new_key (hit_new_key_vec[i]),
            .shift_out   (shift_chain[i+1])
        );
    end

    // keys are unique, so at most one cell hits and an or-merge picks its payload
    always_comb begin
        sel_payload = '0;
        for (int i = 0; i < DEPTH; i++) begin
            sel_payload = sel_payload | (cell_payload[i] & {PAY_W{hit_key_vec[i]}});
        end
    end

    assign any_hit     = |hit_key_vec;
    assign any_new_hit = |hit_new_key_vec;
    assign full        = ({{(CMP_W - CNT_W){1'b0}}, count_reg} >=
                          {{(CMP_W - CAP_W){1'b0}}, cap_reg}) ||
                         (count_reg >= CNT_W'(DEPTH));

    // operation decode and commit
    always_comb begin
        status      = ST_OK;
        res_key     = '0;
        res_payload = '0;
        count_next  = count_reg;
        ctrl        = '0;
        case (op_reg)
            OP_ADD: begin
                if (full) begin
                    status = ST_FULL;
                end else if (any_hit) begin
                    status = ST_DUP;
                end else begin
                    ctrl.add_en = commit;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            OP_DEL: begin
                if (!any_hit) begin
                    status = ST_MISS;
                end else begin
                    ctrl.del_en = commit;
                    count_next  = count_reg - CNT_W'(1);
                end
            end
            OP_UPD: begin
                if (!any_hit) begin
                    status = ST_MISS;
                end else if (any_new_hit) begin
                    status = ST_DUP;
                end else begin
                    ctrl.upd_en = commit;
                end
            end
            OP_GET: begin
                if (!any_hit) begin
                    status = ST_MISS;
                end else begin
                    res_key     = item_key_reg;
                    res_payload = sel_payload;
                end
            end
            default: begin
                status = ST_MISS;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE: if (accept) state_next = SEQ_EXEC;
            SEQ_EXEC: if (out_free) state_next = SEQ_IDLE;
            default:  state_next = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEQ_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (commit) begin
                count_reg <= count_next;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_status_reg <= status;
            m_data_reg   <= M_TDATA_W'({ECNT_W'(count_next), res_payload, res_key});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

endmodule

`default_nettype wire

>>> hw/rtl/ktc_checker.sv
// port-level checker for the keyed table, bound to the top level
`default_nettype none

`include "keyed_table_with_compaction_top_assert.svh"

module ktc_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [ktc_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic [1:0]                     m_tuser
);
    import ktc_pkg::*;

    // no result right after reset
    `KTC_ASSERT_ALWAYS(a_reset_idle, !aresetn, !m_tvalid)

    // one transaction in flight: input closes after a take
    `KTC_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

    // a missed lookup returns zero key and payload
    `KTC_ASSERT_NOW(a_miss_zero, m_tvalid && (m_tuser == ST_MISS),
        m_tdata[KEY_W+PAY_W-1:0] == '0)

    // a stalled result holds
    `KTC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind keyed_table_with_compaction_top ktc_checker u_ktc_checker (.*);

`default_nettype wire
